[rtl/cta_pkg.sv]
// Shared types and constants for the client table with aging.
package cta_pkg;

    localparam int OP_W   = 2;
    localparam int ADDR_W = 48;
    localparam int NOW_W  = 32;
    localparam int DATA_W = 32;

    // Byte address of the configuration port; bit 2 selects the register word.
    localparam int PADDR_W = 3;

    localparam int DEF_TABLE_SLOTS = 32;
    localparam int DEF_TIME_BITS   = 32;
    localparam int DEF_SLOT_W      = (DEF_TABLE_SLOTS > 1) ? $clog2(DEF_TABLE_SLOTS) : 1;
    localparam int DEF_CNT_W       = $clog2(DEF_TABLE_SLOTS + 1);

    localparam logic [DATA_W-1:0] TIMEOUT_RESET = 32'd5000;

    // Register word index on the configuration port.
    localparam logic REG_TIMEOUT = 1'b0;

    // Operation codes carried by a request.
    localparam logic [OP_W-1:0] OP_RECV = 2'd0;
    localparam logic [OP_W-1:0] OP_SEND = 2'd1;
    localparam logic [OP_W-1:0] OP_ADD  = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP  = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_RESP,
        S_EMIT_CHK,
        S_EMIT_LD
    } t_state;

endpackage

[rtl/cta_if.sv]
// Request and result channel interfaces of the client table with aging.
interface cta_in_if;
    import cta_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   opcode;
    logic [ADDR_W-1:0] peer_addr;
    logic [NOW_W-1:0]  now_ms;

    modport source (output valid, opcode, peer_addr, now_ms, input ready);
    modport sink   (input valid, opcode, peer_addr, now_ms, output ready);
endinterface

interface cta_out_if #(
    parameter int SLOT_W = cta_pkg::DEF_SLOT_W,
    parameter int CNT_W  = cta_pkg::DEF_CNT_W
);
    import cta_pkg::*;

    logic              valid;
    logic              ready;
    logic              dest_valid;
    logic [ADDR_W-1:0] dest_addr;
    logic [SLOT_W-1:0] dest_slot;
    logic              was_inserted;
    logic              table_full;
    logic [CNT_W-1:0]  active_count;
    logic              last;

    modport source (output valid, dest_valid, dest_addr, dest_slot, was_inserted,
                    table_full, active_count, last, input ready);
    modport sink   (input valid, dest_valid, dest_addr, dest_slot, was_inserted,
                    table_full, active_count, last, output ready);
endinterface

[rtl/client_table_with_aging_core.sv]
// Peer address table with aging: learning, refresh, explicit add and send fan-out.
// Each receive, add or send request to a non-empty table visits every slot once
// through a single read port on the address and time memories, one slot a cycle,
// and a shared age and match compare evaluates the slot read in the previous
// cycle. A receive or add request gives its one result after the scan, and the
// block then takes the next request; a result waiting in the output register
// does not hold up the next request. A send request spends the same scan ageing
// the table and then walks it again up to the last live slot, skipping empty
// slots and giving one result per live slot as the output register frees; a send
// to an empty table, or a request with the unused code, skips the scan and gives
// one result. The address and last-seen memories need no clearing pass: the valid
// bits are flip-flops cleared by reset, and an entry is only used once written.
module client_table_with_aging_core #(
    parameter int TABLE_SLOTS = cta_pkg::DEF_TABLE_SLOTS,
    parameter int TIME_BITS   = cta_pkg::DEF_TIME_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    cta_in_if.sink                       i_in,
    cta_out_if.source                    o_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [cta_pkg::PADDR_W-1:0]  paddr,
    input  logic [cta_pkg::DATA_W-1:0]   pwdata,
    output logic [cta_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);
    import cta_pkg::*;

    localparam int SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CNT_W  = $clog2(TABLE_SLOTS + 1);
    localparam int CMP_W  = (TIME_BITS > DATA_W) ? TIME_BITS : DATA_W;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);

    t_state r_state, n_state;

    logic [DATA_W-1:0]      r_timeout;
    logic [OP_W-1:0]        r_op;
    logic [ADDR_W-1:0]      r_addr;
    logic [TIME_BITS-1:0]   r_now;
    logic [TABLE_SLOTS-1:0] r_valid;
    logic [CNT_W-1:0]       r_live;

    logic [SLOT_W-1:0]      r_ptr;
    logic                   r_issue_on;
    logic                   r_eval_vld;
    logic [SLOT_W-1:0]      r_eval_slot;
    logic                   r_hit_found;
    logic [SLOT_W-1:0]      r_hit_slot;
    logic                   r_free_found;
    logic [SLOT_W-1:0]      r_free_slot;
    logic                   r_last_found;
    logic [SLOT_W-1:0]      r_last_slot;

    logic [ADDR_W-1:0]      r_entry_addr [TABLE_SLOTS];
    logic [TIME_BITS-1:0]   r_entry_seen [TABLE_SLOTS];
    logic [ADDR_W-1:0]      r_rd_addr;
    logic [TIME_BITS-1:0]   r_rd_seen;

    logic                   r_out_valid;
    logic                   r_out_dv;
    logic [ADDR_W-1:0]      r_out_addr;
    logic [SLOT_W-1:0]      r_out_slot;
    logic                   r_out_ins;
    logic                   r_out_full;
    logic [CNT_W-1:0]       r_out_count;
    logic                   r_out_last;

    // Control decoded from the state.
    logic in_ready;
    logic rd_en;
    logic load_resp;
    logic load_emit;

    logic                   accept;
    logic                   out_free;
    logic                   age_en;
    logic                   match_en;
    logic [TIME_BITS-1:0]   age_diff;
    logic                   ev_v;
    logic                   ev_stale;
    logic                   ev_live;
    logic                   ev_match;
    logic                   scan_eval;
    logic                   scan_end;
    logic                   n_last_found;
    logic                   ptr_valid;
    logic                   emit_last;

    logic                   ins_op;
    logic                   do_ins;
    logic                   resp_dv;
    logic [SLOT_W-1:0]      resp_slot;

    assign accept   = i_in.valid && in_ready;
    assign out_free = !r_out_valid || o_out.ready;
    assign age_en   = (r_op == OP_RECV) || (r_op == OP_SEND);
    assign match_en = (r_op == OP_RECV);

    // Shared age and match unit, applied to the slot read in the previous cycle.
    assign age_diff  = r_now - r_rd_seen;
    assign ev_v      = r_valid[r_eval_slot];
    assign ev_stale  = age_en && ev_v && (CMP_W'(age_diff) > CMP_W'(r_timeout));
    assign ev_live   = ev_v && !ev_stale;
    assign ev_match  = match_en && ev_live && (r_rd_addr == r_addr);
    assign scan_eval = (r_state == S_SCAN) && r_eval_vld;
    assign scan_end  = scan_eval && (r_eval_slot == LAST_SLOT);
    assign n_last_found = r_last_found || (scan_eval && ev_live);

    assign ptr_valid = r_valid[r_ptr];
    assign emit_last = (r_ptr == r_last_slot);

    // Single result of receive, add, an empty send or an unused code.
    assign ins_op    = ((r_op == OP_RECV) && !r_hit_found) || (r_op == OP_ADD);
    assign do_ins    = ins_op && r_free_found;
    assign resp_dv   = ((r_op == OP_RECV) && r_hit_found) || do_ins;
    assign resp_slot = r_hit_found ? r_hit_slot : (do_ins ? r_free_slot : '0);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    if (i_in.opcode == OP_NOP) begin
                        n_state = S_RESP;
                    end else if ((i_in.opcode == OP_SEND) && (r_live == '0)) begin
                        n_state = S_RESP;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (scan_end) begin
                    if ((r_op == OP_SEND) && n_last_found) begin
                        n_state = S_EMIT_CHK;
                    end else begin
                        n_state = S_RESP;
                    end
                end
            end
            S_RESP: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_EMIT_CHK: begin
                if (ptr_valid) begin
                    n_state = S_EMIT_LD;
                end
            end
            S_EMIT_LD: begin
                if (out_free) begin
                    n_state = emit_last ? S_IDLE : S_EMIT_CHK;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        in_ready  = 1'b0;
        rd_en     = 1'b0;
        load_resp = 1'b0;
        load_emit = 1'b0;
        case (r_state)
            S_IDLE: begin
                in_ready = 1'b1;
            end
            S_SCAN: begin
                rd_en = r_issue_on;
            end
            S_RESP: begin
                load_resp = out_free;
            end
            S_EMIT_CHK: begin
                rd_en = ptr_valid;
            end
            S_EMIT_LD: begin
                load_emit = out_free;
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
        end else if (psel && penable && pwrite && (paddr[PADDR_W-1] == REG_TIMEOUT)) begin
            r_timeout <= pwdata;
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[PADDR_W-1] == REG_TIMEOUT) ? r_timeout : '0;

    // Latched request.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= i_in.opcode;
            r_addr <= i_in.peer_addr;
            r_now  <= TIME_BITS'(i_in.now_ms);
        end
    end

    // Scan sequencer and its running results.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr        <= '0;
            r_issue_on   <= 1'b0;
            r_eval_vld   <= 1'b0;
            r_hit_found  <= 1'b0;
            r_free_found <= 1'b0;
            r_last_found <= 1'b0;
        end else begin
            if (accept) begin
                r_ptr        <= '0;
                r_issue_on   <= 1'b1;
                r_eval_vld   <= 1'b0;
                r_hit_found  <= 1'b0;
                r_free_found <= 1'b0;
                r_last_found <= 1'b0;
            end
            if (r_state == S_SCAN) begin
                if (r_issue_on) begin
                    r_eval_slot <= r_ptr;
                    r_eval_vld  <= 1'b1;
                    if (r_ptr == LAST_SLOT) begin
                        r_issue_on <= 1'b0;
                    end else begin
                        r_ptr <= r_ptr + 1'b1;
                    end
                end else begin
                    r_eval_vld <= 1'b0;
                end
            end
            if (scan_eval) begin
                if (ev_match && !r_hit_found) begin
                    r_hit_found <= 1'b1;
                    r_hit_slot  <= r_eval_slot;
                end
                if (!ev_live && !r_free_found) begin
                    r_free_found <= 1'b1;
                    r_free_slot  <= r_eval_slot;
                end
                if (ev_live) begin
                    r_last_found <= 1'b1;
                    r_last_slot  <= r_eval_slot;
                end
            end
            // The fan-out walks the table again from the first slot.
            if (scan_end) begin
                r_ptr <= '0;
            end
            if ((r_state == S_EMIT_CHK) && !ptr_valid) begin
                r_ptr <= r_ptr + 1'b1;
            end
            if (load_emit && !emit_last) begin
                r_ptr <= r_ptr + 1'b1;
            end
        end
    end

    // Valid bits and live count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_live  <= '0;
        end else begin
            if (scan_eval && ev_stale) begin
                r_valid[r_eval_slot] <= 1'b0;
                r_live               <= r_live - 1'b1;
            end
            if (load_resp && do_ins) begin
                r_valid[r_free_slot] <= 1'b1;
                r_live               <= r_live + 1'b1;
            end
        end
    end

    // Address and last-seen memories: one read port, one write port each.
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_addr <= r_entry_addr[r_ptr];
            r_rd_seen <= r_entry_seen[r_ptr];
        end
        if (scan_eval && ev_match) begin
            r_entry_seen[r_eval_slot] <= r_now;
        end
        if (load_resp && do_ins) begin
            r_entry_addr[r_free_slot] <= r_addr;
            r_entry_seen[r_free_slot] <= r_now;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_resp || load_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_resp) begin
            r_out_dv    <= resp_dv;
            r_out_addr  <= resp_dv ? r_addr : '0;
            r_out_slot  <= resp_slot;
            r_out_ins   <= do_ins;
            r_out_full  <= ins_op && !r_free_found;
            r_out_count <= r_live + CNT_W'(do_ins);
            r_out_last  <= 1'b1;
        end else if (load_emit) begin
            r_out_dv    <= 1'b1;
            r_out_addr  <= r_rd_addr;
            r_out_slot  <= r_ptr;
            r_out_ins   <= 1'b0;
            r_out_full  <= 1'b0;
            r_out_count <= r_live;
            r_out_last  <= emit_last;
        end
    end

    assign i_in.ready         = in_ready;
    assign o_out.valid        = r_out_valid;
    assign o_out.dest_valid   = r_out_dv;
    assign o_out.dest_addr    = r_out_addr;
    assign o_out.dest_slot    = r_out_slot;
    assign o_out.was_inserted = r_out_ins;
    assign o_out.table_full   = r_out_full;
    assign o_out.active_count = r_out_count;
    assign o_out.last         = r_out_last;

    // The live count always agrees with the valid bits.
    a_live_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == r_live)
        else $error("live count differs from the number of valid slots");

    // An accepted request always starts work before the next one is taken.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state != S_IDLE))
        else $error("block idle straight after accepting a request");

    // A dropped insert is only reported with every slot in use.
    a_full_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.table_full) |->
            (o_out.active_count == CNT_W'(TABLE_SLOTS)) && !o_out.dest_valid)
        else $error("table full reported with free slots");

endmodule
